// ===== sv/bpa_pkg.sv =====
// Shared types, codes and helpers for the buddy page allocator.
// Depends on nothing; imported by buddy_page_allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   // Frame store geometry
   localparam int PAGE_COUNT  = 1024;
   localparam int ORDER_COUNT = 11;
   localparam int PAGE_W      = 10;
   localparam int LINK_W      = 11;
   localparam int ORD_W       = 4;
   localparam int CNT_W       = 11;
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 2;
   localparam int CSR_IDX_W   = 1;

   localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(PAGE_COUNT);
   localparam logic [ORD_W-1:0]  ORDER_MAX = ORD_W'(ORDER_COUNT - 1);
   localparam logic [CNT_W:0]    CNT_MAX   = {1'b0, {CNT_W{1'b1}}};

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RANGE = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ZONE_FIRST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ZONE_END   = 1'b1;

   // Page store word: free-head mark and order
   typedef struct packed {
      logic             mark;
      logic [ORD_W-1:0] order;
   } page_word_type;

   // Sequencer states
   typedef enum logic [20:0] {
      S_CLEAR   = 21'h000001,
      S_IDLE    = 21'h000002,
      S_A_SCAN  = 21'h000004,
      S_A_SPLIT = 21'h000008,
      S_U_RD    = 21'h000010,
      S_U_WR    = 21'h000020,
      S_P_RD    = 21'h000040,
      S_P_CHK   = 21'h000080,
      S_P_LINK  = 21'h000100,
      S_P_BACK  = 21'h000200,
      S_F_RD    = 21'h000400,
      S_F_CHK   = 21'h000800,
      S_M_START = 21'h001000,
      S_M_TEST  = 21'h002000,
      S_M_RD    = 21'h004000,
      S_M_CHK   = 21'h008000,
      S_M_MERGE = 21'h010000,
      S_R_CHK   = 21'h020000,
      S_R_TEST  = 21'h040000,
      S_R_FREE  = 21'h080000,
      S_DONE    = 21'h100000
   } state_type;

   // Add with saturation at the counter maximum
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + b;
      return (s > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : s[CNT_W-1:0];
   endfunction

   // Largest aligned block at p that fits below e (p < e)
   function automatic logic [ORD_W-1:0] carve_order(input logic [LINK_W-1:0] p,
                                                    input logic [LINK_W-1:0] e);
      logic [LINK_W-1:0] rem;
      logic [ORD_W-1:0]  tz;
      logic [ORD_W-1:0]  msb;
      logic              found;
      rem   = e - p;
      tz    = ORDER_MAX;
      found = 1'b0;
      msb   = '0;
      for (int i = 0; i < ORDER_COUNT - 1; i++) begin
         if (!found && p[i]) begin
            tz    = ORD_W'(i);
            found = 1'b1;
         end
      end
      for (int i = 0; i < LINK_W; i++) begin
         if (rem[i]) msb = ORD_W'(i);
      end
      return (msb < tz) ? msb : tz;
   endfunction

endpackage

// ===== sv/buddy_page_allocator.sv =====
// Buddy page allocator: sequencer, page store, link stores and free lists.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

// From accept to result: alloc scans orders upward for a non-empty list, unlinks its head,
// pushes each split half and closes; free reads the page store, then takes merge steps and
// pushes the block; a range runs a check pass over its carved blocks, then a free sequence
// per block. A bad request goes straight to the result state.
// One item at a time: input stalls until the result loads, next item taken the cycle after.
// After reset the page store is swept clear; no item is taken during the sweep.
module buddy_page_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bpa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bpa_pkg::ORD_W-1:0]     req_block_order,
   input  logic [bpa_pkg::PAGE_W-1:0]    req_page_number,
   input  logic [bpa_pkg::LINK_W-1:0]    req_range_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bpa_pkg::STAT_W-1:0]    rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]    rsp_granted_page,
   output logic [bpa_pkg::CNT_W-1:0]     rsp_pages_free,
   output logic [bpa_pkg::CNT_W-1:0]     rsp_pages_managed,
   input  logic                          csr_write,
   input  logic [bpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpa_pkg::LINK_W-1:0]    csr_wdata
);
   import bpa_pkg::*;

   // Control state
   state_type            state_ff, state_in;
   state_type            ret_u_ff, ret_u_in;
   state_type            ret_p_ff, ret_p_in;
   state_type            ret_m_ff, ret_m_in;
   logic [PAGE_W-1:0]    clr_ff, clr_in;
   logic [LINK_W-1:0]    zf_ff, zend_ff;
   logic [LINK_W-1:0]    lhead_ff [ORDER_COUNT];
   logic [CNT_W-1:0]     ft_ff, ft_in;
   logic [CNT_W-1:0]     mt_ff, mt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [ORD_W-1:0]     ord_ff, ord_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [LINK_W-1:0]    rend_ff, rend_in;
   logic [LINK_W-1:0]    cur_p_ff, cur_p_in;
   logic [ORD_W-1:0]     cur_o_ff, cur_o_in;
   logic [PAGE_W-1:0]    un_p_ff, un_p_in;
   logic [ORD_W-1:0]     un_o_ff, un_o_in;
   logic [PAGE_W-1:0]    pu_p_ff, pu_p_in;
   logic [ORD_W-1:0]     pu_o_ff, pu_o_in;
   logic [PAGE_W-1:0]    mi_p_ff, mi_p_in;
   logic [ORD_W-1:0]     mi_o_ff, mi_o_in;
   logic [LINK_W-1:0]    h_ff, h_in;
   logic [STAT_W-1:0]    st_ff, st_in;
   logic [PAGE_W-1:0]    grant_ff, grant_in;
   logic [STAT_W-1:0]    rsp_status_ff;
   logic [PAGE_W-1:0]    rsp_grant_ff;
   logic [CNT_W-1:0]     rsp_free_ff, rsp_managed_ff;

   // Memories
   page_word_type        mo_mem_ff [PAGE_COUNT];
   logic [LINK_W-1:0]    nx_mem_ff [PAGE_COUNT];
   logic [LINK_W-1:0]    pv_mem_ff [PAGE_COUNT];
   page_word_type        mo_rd_ff;
   logic [LINK_W-1:0]    nx_rd_ff, pv_rd_ff;

   logic                 mo_we, nx_we, pv_we;
   logic [PAGE_W-1:0]    mo_waddr, nx_waddr, pv_waddr, mo_raddr;
   page_word_type        mo_wdata;
   logic [LINK_W-1:0]    nx_wdata, pv_wdata;

   logic                 lh_we;
   logic [ORD_W-1:0]     lh_widx, lh_idx;
   logic [LINK_W-1:0]    lh_wdata, lh_rd;

   // Derived values
   logic [LINK_W-1:0]    eend;
   logic                 acc;
   logic                 ord_ok, f_ok, r_ok;
   logic [LINK_W:0]      req_blk;
   logic [PAGE_W-1:0]    req_mask;
   logic [PAGE_W-1:0]    bud;
   logic                 bud_ok;
   logic [ORD_W-1:0]     co;
   logic [ORD_W-1:0]     om1;
   logic [LINK_W:0]      tgt_sz;
   logic                 rsp_load;

   assign eend      = (zend_ff > NIL_LINK) ? NIL_LINK : zend_ff;
   assign acc       = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign lh_rd     = lhead_ff[lh_idx];

   // Request checks
   assign ord_ok   = (req_block_order <= ORDER_MAX);
   assign req_blk  = (LINK_W+1)'(1) << req_block_order;
   assign req_mask = PAGE_W'(req_blk - (LINK_W+1)'(1));
   assign f_ok     = ord_ok && ({1'b0, req_page_number} >= zf_ff)
                     && ({1'b0, req_page_number} < eend)
                     && (({2'b0, req_page_number} + req_blk) <= {1'b0, eend})
                     && ((req_page_number & req_mask) == '0);
   assign r_ok     = ({1'b0, req_page_number} >= zf_ff) && (req_range_end <= eend)
                     && ({1'b0, req_page_number} <= req_range_end);

   // Buddy of the block being merged
   assign bud    = mi_p_ff ^ (PAGE_W'(1) << mi_o_ff);
   assign bud_ok = (mi_o_ff < ORDER_MAX) && ({1'b0, bud} >= zf_ff) && ({1'b0, bud} < eend)
                   && (({1'b0, bud} + (LINK_W'(1) << mi_o_ff)) <= eend);

   assign co     = carve_order(cur_p_ff, rend_ff);
   assign om1    = cur_o_ff - ORD_W'(1);
   assign tgt_sz = (LINK_W+1)'(1) << ord_ff;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      ret_u_in = ret_u_ff;
      ret_p_in = ret_p_ff;
      ret_m_in = ret_m_ff;
      clr_in   = clr_ff;
      ft_in    = ft_ff;
      mt_in    = mt_ff;
      ord_in   = ord_ff;
      page_in  = page_ff;
      rend_in  = rend_ff;
      cur_p_in = cur_p_ff;
      cur_o_in = cur_o_ff;
      un_p_in  = un_p_ff;
      un_o_in  = un_o_ff;
      pu_p_in  = pu_p_ff;
      pu_o_in  = pu_o_ff;
      mi_p_in  = mi_p_ff;
      mi_o_in  = mi_o_ff;
      h_in     = h_ff;
      st_in    = st_ff;
      grant_in = grant_ff;
      mo_we    = 1'b0;
      mo_waddr = pu_p_ff;
      mo_wdata = '{mark: 1'b0, order: '0};
      mo_raddr = pu_p_ff;
      nx_we    = 1'b0;
      nx_waddr = pu_p_ff;
      nx_wdata = NIL_LINK;
      pv_we    = 1'b0;
      pv_waddr = pu_p_ff;
      pv_wdata = NIL_LINK;
      lh_we    = 1'b0;
      lh_widx  = pu_o_ff;
      lh_wdata = NIL_LINK;
      lh_idx   = cur_o_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the free-head marks
            mo_we    = 1'b1;
            mo_waddr = clr_ff;
            clr_in   = clr_ff + PAGE_W'(1);
            if (clr_ff == {PAGE_W{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               ord_in   = req_block_order;
               page_in  = req_page_number;
               rend_in  = req_range_end;
               grant_in = '0;
               st_in    = ST_BAD;
               state_in = S_DONE;
               unique case (req_cmd)
                  CMD_ALLOC: begin
                     if (ord_ok) begin
                        cur_o_in = req_block_order;
                        state_in = S_A_SCAN;
                     end
                  end
                  CMD_FREE: begin
                     if (f_ok) state_in = S_F_RD;
                  end
                  CMD_RANGE: begin
                     if (r_ok) begin
                        cur_p_in = {1'b0, req_page_number};
                        state_in = S_R_CHK;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_A_SCAN: begin
            // walk orders upward for a non-empty list
            if (lh_rd != NIL_LINK) begin
               cur_p_in = lh_rd;
               un_p_in  = lh_rd[PAGE_W-1:0];
               un_o_in  = cur_o_ff;
               ret_u_in = S_A_SPLIT;
               state_in = S_U_RD;
            end else if (cur_o_ff == ORDER_MAX) begin
               st_in    = ST_NOSPACE;
               state_in = S_DONE;
            end else begin
               cur_o_in = cur_o_ff + ORD_W'(1);
            end
         end
         S_A_SPLIT: begin
            // push upper halves until the block has the asked order
            if (cur_o_ff > ord_ff) begin
               cur_o_in = om1;
               pu_p_in  = cur_p_ff[PAGE_W-1:0] + (PAGE_W'(1) << om1);
               pu_o_in  = om1;
               ret_p_in = S_A_SPLIT;
               state_in = S_P_RD;
            end else begin
               mo_we    = 1'b1;
               mo_waddr = cur_p_ff[PAGE_W-1:0];
               mo_wdata = '{mark: 1'b0, order: ord_ff};
               ft_in    = ({1'b0, ft_ff} >= tgt_sz) ? CNT_W'({1'b0, ft_ff} - tgt_sz) : '0;
               grant_in = cur_p_ff[PAGE_W-1:0];
               st_in    = ST_DONE;
               state_in = S_DONE;
            end
         end
         S_U_RD: begin
            state_in = S_U_WR;
         end
         S_U_WR: begin
            // bypass the node in its list and drop its mark
            if (pv_rd_ff < NIL_LINK) begin
               nx_we    = 1'b1;
               nx_waddr = pv_rd_ff[PAGE_W-1:0];
               nx_wdata = nx_rd_ff;
            end else begin
               lh_we    = 1'b1;
               lh_widx  = un_o_ff;
               lh_wdata = nx_rd_ff;
            end
            if (nx_rd_ff < NIL_LINK) begin
               pv_we    = 1'b1;
               pv_waddr = nx_rd_ff[PAGE_W-1:0];
               pv_wdata = pv_rd_ff;
            end
            mo_we    = 1'b1;
            mo_waddr = un_p_ff;
            mo_wdata = '{mark: 1'b0, order: un_o_ff};
            state_in = ret_u_ff;
         end
         S_P_RD: begin
            mo_raddr = pu_p_ff;
            state_in = S_P_CHK;
         end
         S_P_CHK: begin
            if (mo_rd_ff.mark) begin
               un_p_in  = pu_p_ff;
               un_o_in  = mo_rd_ff.order;
               ret_u_in = S_P_LINK;
               state_in = S_U_RD;
            end else begin
               state_in = S_P_LINK;
            end
         end
         S_P_LINK: begin
            // insert at the list head
            lh_idx   = pu_o_ff;
            h_in     = lh_rd;
            mo_we    = 1'b1;
            mo_waddr = pu_p_ff;
            mo_wdata = '{mark: 1'b1, order: pu_o_ff};
            nx_we    = 1'b1;
            nx_waddr = pu_p_ff;
            nx_wdata = lh_rd;
            pv_we    = 1'b1;
            pv_waddr = pu_p_ff;
            pv_wdata = NIL_LINK;
            lh_we    = 1'b1;
            lh_widx  = pu_o_ff;
            lh_wdata = {1'b0, pu_p_ff};
            state_in = S_P_BACK;
         end
         S_P_BACK: begin
            if (h_ff < NIL_LINK) begin
               pv_we    = 1'b1;
               pv_waddr = h_ff[PAGE_W-1:0];
               pv_wdata = {1'b0, pu_p_ff};
            end
            state_in = ret_p_ff;
         end
         S_F_RD: begin
            mo_raddr = page_ff;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (mo_rd_ff.mark) begin
               state_in = S_DONE;
            end else begin
               st_in    = ST_DONE;
               mi_p_in  = page_ff;
               mi_o_in  = ord_ff;
               ret_m_in = S_DONE;
               state_in = S_M_START;
            end
         end
         S_M_START: begin
            ft_in    = sat_add(ft_ff, (CNT_W+1)'(1) << mi_o_ff);
            state_in = S_M_TEST;
         end
         S_M_TEST: begin
            if (bud_ok) begin
               state_in = S_M_RD;
            end else begin
               pu_p_in  = mi_p_ff;
               pu_o_in  = mi_o_ff;
               ret_p_in = ret_m_ff;
               state_in = S_P_RD;
            end
         end
         S_M_RD: begin
            mo_raddr = bud;
            state_in = S_M_CHK;
         end
         S_M_CHK: begin
            if (mo_rd_ff.mark && (mo_rd_ff.order == mi_o_ff)) begin
               un_p_in  = bud;
               un_o_in  = mi_o_ff;
               ret_u_in = S_M_MERGE;
               state_in = S_U_RD;
            end else begin
               pu_p_in  = mi_p_ff;
               pu_o_in  = mi_o_ff;
               ret_p_in = ret_m_ff;
               state_in = S_P_RD;
            end
         end
         S_M_MERGE: begin
            mi_p_in  = mi_p_ff & ~(PAGE_W'(1) << mi_o_ff);
            mi_o_in  = mi_o_ff + ORD_W'(1);
            state_in = S_M_TEST;
         end
         S_R_CHK: begin
            // check pass over the carved heads
            mo_raddr = cur_p_ff[PAGE_W-1:0];
            if (cur_p_ff < rend_ff) begin
               state_in = S_R_TEST;
            end else begin
               mt_in    = sat_add(mt_ff, {1'b0, rend_ff - {1'b0, page_ff}});
               cur_p_in = {1'b0, page_ff};
               state_in = S_R_FREE;
            end
         end
         S_R_TEST: begin
            if (mo_rd_ff.mark) begin
               state_in = S_DONE;
            end else begin
               cur_p_in = cur_p_ff + (LINK_W'(1) << co);
               state_in = S_R_CHK;
            end
         end
         S_R_FREE: begin
            // free pass over the carved blocks
            if (cur_p_ff < rend_ff) begin
               mi_p_in  = cur_p_ff[PAGE_W-1:0];
               mi_o_in  = co;
               cur_p_in = cur_p_ff + (LINK_W'(1) << co);
               ret_m_in = S_R_FREE;
               state_in = S_M_START;
            end else begin
               st_in    = ST_DONE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_u_ff     <= S_IDLE;
         ret_p_ff     <= S_IDLE;
         ret_m_ff     <= S_IDLE;
         clr_ff       <= '0;
         ft_ff        <= '0;
         mt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ORDER_COUNT; i++) lhead_ff[i] <= NIL_LINK;
      end else begin
         state_ff     <= state_in;
         ret_u_ff     <= ret_u_in;
         ret_p_ff     <= ret_p_in;
         ret_m_ff     <= ret_m_in;
         clr_ff       <= clr_in;
         ft_ff        <= ft_in;
         mt_ff        <= mt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (lh_we) lhead_ff[lh_widx] <= lh_wdata;
      end
   end

   // Zone registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zf_ff   <= '0;
         zend_ff <= NIL_LINK;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ZONE_FIRST: zf_ff   <= csr_wdata;
            REG_ZONE_END:   zend_ff <= csr_wdata;
            default:        zf_ff   <= zf_ff;
         endcase
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      ord_ff   <= ord_in;
      page_ff  <= page_in;
      rend_ff  <= rend_in;
      cur_p_ff <= cur_p_in;
      cur_o_ff <= cur_o_in;
      un_p_ff  <= un_p_in;
      un_o_ff  <= un_o_in;
      pu_p_ff  <= pu_p_in;
      pu_o_ff  <= pu_o_in;
      mi_p_ff  <= mi_p_in;
      mi_o_ff  <= mi_o_in;
      h_ff     <= h_in;
      st_ff    <= st_in;
      grant_ff <= grant_in;
      if (rsp_load) begin
         rsp_status_ff  <= st_ff;
         rsp_grant_ff   <= grant_ff;
         rsp_free_ff    <= ft_ff;
         rsp_managed_ff <= mt_ff;
      end
   end

   // Page store and link stores
   always_ff @(posedge clock) begin
      if (mo_we) mo_mem_ff[mo_waddr] <= mo_wdata;
      mo_rd_ff <= mo_mem_ff[mo_raddr];
   end

   always_ff @(posedge clock) begin
      if (nx_we) nx_mem_ff[nx_waddr] <= nx_wdata;
      nx_rd_ff <= nx_mem_ff[un_p_ff];
   end

   always_ff @(posedge clock) begin
      if (pv_we) pv_mem_ff[pv_waddr] <= pv_wdata;
      pv_rd_ff <= pv_mem_ff[un_p_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_page  = rsp_grant_ff;
   assign rsp_pages_free    = rsp_free_ff;
   assign rsp_pages_managed = rsp_managed_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a second item while busy");

   a_grant_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_granted_page == '0))
      else $error("granted page on a failed command");

   a_merge_order_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_M_TEST) |-> (mi_o_ff <= ORDER_MAX))
      else $error("merge order past the top order");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

endmodule
